### rtl/core/mddc_pkg.sv
package mddc_pkg;

  // Result codes
  typedef enum logic [2:0] {
    STATUS_UNDECIDED = 3'd0,
    STATUS_CONSTANT  = 3'd1,
    STATUS_TOWARDS   = 3'd2,
    STATUS_AWAY      = 3'd3,
    STATUS_TOGGLING  = 3'd4
  } status_t;

  // Register indexes on the configuration port
  localparam int CFG_INDEX_BITS = 3;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  localparam cfg_index_t CFG_STILL_BAND   = 3'd0;
  localparam cfg_index_t CFG_MOVE_BAND    = 3'd1;
  localparam cfg_index_t CFG_STILL_TICKS  = 3'd2;
  localparam cfg_index_t CFG_PITCH_TARGET = 3'd3;
  localparam cfg_index_t CFG_YAW_TARGET   = 3'd4;

  localparam int BAND_BITS  = 15;
  localparam int TICKS_BITS = 16;

  localparam logic [BAND_BITS-1:0]  STILL_BAND_RESET  = 15'd70;
  localparam logic [BAND_BITS-1:0]  MOVE_BAND_RESET   = 15'd286;
  localparam logic [TICKS_BITS-1:0] STILL_TICKS_RESET = 16'd5;

  // Channel tracking: no sample seen yet on any channel
  localparam logic [1:0] CHANNEL_NONE = 2'd2;

  localparam int OUT_DATA_BITS = 8;

endpackage

### rtl/core/motion_direction_debounce_classifier.sv
// Pipeline: a sample's result passes the input register, then the result register,
//   before it shows on the output; a tick item gives no result.
// Throughput: one item per cycle, stalled only while the result register is full
//   and not taken; the state update sits in one compare/add stage.
// Reset (rst, synchronous, active high): restores register defaults, arms the
//   reference latch, clears timer and channel tracking, and empties the pipeline.
module motion_direction_debounce_classifier #(
  parameter int ANGLE_BITS = 16,
  parameter int TIMER_BITS = 16
) (
  input  logic clk,
  input  logic rst,

  // Input item stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: angle (signed), zero padding above
  input  logic [((ANGLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // tuser: [0] mode (1 = tick), [1] channel (1 = yaw)
  input  logic [1:0]                          s_axis_tuser,

  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: status [2:0], zero padding above
  output logic [mddc_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,

  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  mddc_pkg::cfg_index_t                cfg_index,
  input  logic [((ANGLE_BITS > 16) ? ANGLE_BITS : 16)-1:0] cfg_data
);
  import mddc_pkg::*;

  localparam int DistBits = ANGLE_BITS + 1;
  localparam int CmpBits  = (DistBits > BAND_BITS) ? DistBits : BAND_BITS;
  localparam int TickCmp  = (TIMER_BITS > TICKS_BITS) ? TIMER_BITS : TICKS_BITS;

  // Configuration registers
  logic [BAND_BITS-1:0]  still_band;
  logic [BAND_BITS-1:0]  move_band;
  logic [TICKS_BITS-1:0] still_ticks;
  logic [ANGLE_BITS-1:0] pitch_target;
  logic [ANGLE_BITS-1:0] yaw_target;

  // Classifier state
  logic                  armed_fresh;
  logic [1:0]            last_channel;
  logic [ANGLE_BITS-1:0] reference_angle;
  logic                  wanted_rising;
  logic [TIMER_BITS-1:0] still_timer;

  logic                  armed_fresh_next;
  logic [1:0]            last_channel_next;
  logic [ANGLE_BITS-1:0] reference_angle_next;
  logic                  wanted_rising_next;
  logic [TIMER_BITS-1:0] still_timer_next;
  status_t               status_next;

  // Input register
  logic                  in_valid;
  logic                  in_mode;
  logic                  in_channel;
  logic [ANGLE_BITS-1:0] in_angle;

  // Result register
  logic                  out_valid;
  status_t               out_status;

  logic advance;

  // The whole pipe moves when the result slot is free or being emptied.
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_BITS - 3)'(0), out_status};

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      still_band   <= STILL_BAND_RESET;
      move_band    <= MOVE_BAND_RESET;
      still_ticks  <= STILL_TICKS_RESET;
      pitch_target <= '0;
      yaw_target   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STILL_BAND:   still_band   <= cfg_data[BAND_BITS-1:0];
        CFG_MOVE_BAND:    move_band    <= cfg_data[BAND_BITS-1:0];
        CFG_STILL_TICKS:  still_ticks  <= cfg_data[TICKS_BITS-1:0];
        CFG_PITCH_TARGET: pitch_target <= cfg_data[ANGLE_BITS-1:0];
        CFG_YAW_TARGET:   yaw_target   <= cfg_data[ANGLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Capture the item into the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mode    <= s_axis_tuser[0];
      in_channel <= s_axis_tuser[1];
      in_angle   <= s_axis_tdata[ANGLE_BITS-1:0];
    end
  end

  // Classification of the registered item against the current state.
  logic signed [DistBits-1:0] cur_ext;
  logic signed [DistBits-1:0] ref_ext;
  logic signed [DistBits-1:0] tgt_ext;
  logic [DistBits-1:0]        distance;
  logic                       cur_gt_ref;
  logic                       latch_ref;
  logic                       is_still;
  logic                       is_move;
  logic                       timer_done;
  logic [ANGLE_BITS-1:0]      target_sel;

  always_comb begin
    target_sel = in_channel ? yaw_target : pitch_target;
    cur_ext    = $signed({in_angle[ANGLE_BITS-1], in_angle});
    ref_ext    = $signed({reference_angle[ANGLE_BITS-1], reference_angle});
    tgt_ext    = $signed({target_sel[ANGLE_BITS-1], target_sel});
    cur_gt_ref = cur_ext > ref_ext;
    // Distance is exact: one extra bit keeps the difference from wrapping.
    distance   = cur_gt_ref ? DistBits'(cur_ext - ref_ext) : DistBits'(ref_ext - cur_ext);
    latch_ref  = armed_fresh || (last_channel != {1'b0, in_channel});
    // Still test wins when the bands overlap.
    is_still   = CmpBits'(distance) <= CmpBits'(still_band);
    is_move    = CmpBits'(distance) > CmpBits'(move_band);
    timer_done = TickCmp'(still_timer) > TickCmp'(still_ticks);
  end

  always_comb begin
    armed_fresh_next     = armed_fresh;
    last_channel_next    = last_channel;
    reference_angle_next = reference_angle;
    wanted_rising_next   = wanted_rising;
    still_timer_next     = still_timer;
    status_next          = STATUS_UNDECIDED;

    if (in_mode) begin
      // Tick: advance the timer, hold at all ones.
      if (still_timer != '1) begin
        still_timer_next = still_timer + 1'b1;
      end
    end else begin
      last_channel_next = {1'b0, in_channel};
      priority if (latch_ref) begin
        // Latch a fresh reference and the goal direction.
        reference_angle_next = in_angle;
        wanted_rising_next   = tgt_ext > cur_ext;
        armed_fresh_next     = 1'b0;
        still_timer_next     = '0;
      end else if (is_still) begin
        if (timer_done) begin
          status_next      = STATUS_CONSTANT;
          armed_fresh_next = 1'b1;
          still_timer_next = '0;
        end
      end else if (is_move) begin
        status_next      = (wanted_rising == cur_gt_ref) ? STATUS_TOWARDS : STATUS_AWAY;
        armed_fresh_next = 1'b1;
        still_timer_next = '0;
      end else begin
        status_next      = STATUS_TOGGLING;
        still_timer_next = '0;
      end
    end
  end

  // Commit state and load the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      armed_fresh     <= 1'b1;
      last_channel    <= CHANNEL_NONE;
      reference_angle <= '0;
      wanted_rising   <= 1'b0;
      still_timer     <= '0;
      out_valid       <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid && !in_mode;
      if (in_valid) begin
        armed_fresh     <= armed_fresh_next;
        last_channel    <= last_channel_next;
        reference_angle <= reference_angle_next;
        wanted_rising   <= wanted_rising_next;
        still_timer     <= still_timer_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid && !in_mode) begin
      out_status <= status_next;
    end
  end

endmodule

### rtl/core/mddc_checker.sv
module mddc_assertions (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [mddc_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata
);
  import mddc_pkg::*;

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Status is always a defined code.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= STATUS_TOGGLING)
    else $error("status code out of range");

  // Padding above the status stays zero.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_DATA_BITS-1:3] == '0)
    else $error("nonzero padding in result");

  // Input side only backs up behind a full, stalled result.
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a waiting result");

endmodule

bind motion_direction_debounce_classifier mddc_assertions u_mddc_assertions (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/sv/mddc_checker.sv
module mddc_checker #(
  parameter int ANGLE_BITS = 16,
  parameter int TIMER_BITS = 16
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             s_axis_tvalid,
  input  logic                                             s_axis_tready,
  input  logic [((ANGLE_BITS+7)/8)*8-1:0]                  s_axis_tdata,
  input  logic [1:0]                                       s_axis_tuser,
  input  logic                                             m_axis_tvalid,
  input  logic                                             m_axis_tready,
  input  logic [mddc_pkg::OUT_DATA_BITS-1:0]               m_axis_tdata,
  input  logic                                             cfg_valid,
  input  logic                                             cfg_ready,
  input  mddc_pkg::cfg_index_t                             cfg_index,
  input  logic [((ANGLE_BITS > 16) ? ANGLE_BITS : 16)-1:0] cfg_data,
  output int                                               fail_count,
  output int                                               pending
);
  import mddc_pkg::*;

  // Register copy
  logic [BAND_BITS-1:0]          still_band;
  logic [BAND_BITS-1:0]          move_band;
  logic [TICKS_BITS-1:0]         still_ticks;
  logic signed [ANGLE_BITS-1:0]  pitch_target;
  logic signed [ANGLE_BITS-1:0]  yaw_target;

  // Classifier state copy
  logic                          armed;
  logic [1:0]                    last_chan;
  logic signed [ANGLE_BITS-1:0]  ref_angle;
  logic                          rising;
  logic [TIMER_BITS-1:0]         still_timer;

  status_t                       expected_status_q[$];
  status_t                       next_status;
  status_t                       want;
  logic [OUT_DATA_BITS-1:0]      want_data;

  // Advance the state by one item; return 1 when the item yields a status.
  function automatic bit classify_item(input logic is_tick,
                                       input logic signed [ANGLE_BITS-1:0] angle,
                                       input logic chan,
                                       output status_t status);
    longint                       cur;
    longint                       refv;
    longint                       distance;
    logic signed [ANGLE_BITS-1:0] goal;
    status = STATUS_UNDECIDED;
    if (is_tick) begin
      if (~&still_timer) still_timer = still_timer + 1'b1;
      return 1'b0;
    end
    cur = angle;
    if (armed || {1'b0, chan} != last_chan) begin
      goal        = chan ? yaw_target : pitch_target;
      ref_angle   = angle;
      rising      = goal > angle;
      armed       = 1'b0;
      still_timer = '0;
    end else begin
      refv     = ref_angle;
      distance = (cur > refv) ? cur - refv : refv - cur;
      if (distance <= longint'(still_band)) begin
        // hold the timer until it runs past the limit
        if (still_timer > still_ticks) begin
          status      = STATUS_CONSTANT;
          armed       = 1'b1;
          still_timer = '0;
        end
      end else if (distance > longint'(move_band)) begin
        status      = (rising == (cur > refv)) ? STATUS_TOWARDS : STATUS_AWAY;
        armed       = 1'b1;
        still_timer = '0;
      end else begin
        status      = STATUS_TOGGLING;
        still_timer = '0;
      end
    end
    last_chan = {1'b0, chan};
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      still_band   = STILL_BAND_RESET;
      move_band    = MOVE_BAND_RESET;
      still_ticks  = STILL_TICKS_RESET;
      pitch_target = '0;
      yaw_target   = '0;
      armed        = 1'b1;
      last_chan    = CHANNEL_NONE;
      ref_angle    = '0;
      rising       = 1'b0;
      still_timer  = '0;
      expected_status_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STILL_BAND:   still_band   = cfg_data[BAND_BITS-1:0];
          CFG_MOVE_BAND:    move_band    = cfg_data[BAND_BITS-1:0];
          CFG_STILL_TICKS:  still_ticks  = cfg_data[TICKS_BITS-1:0];
          CFG_PITCH_TARGET: pitch_target = cfg_data[ANGLE_BITS-1:0];
          CFG_YAW_TARGET:   yaw_target   = cfg_data[ANGLE_BITS-1:0];
          default: ;
        endcase
      end
      // Compare before predicting: a result never belongs to an item taken at the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_status_q.size() == 0) begin
          $display("%0t: unexpected result 0x%0h, nothing expected", $time, m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want      = expected_status_q.pop_front();
          want_data = OUT_DATA_BITS'(want);
          if (m_axis_tdata !== want_data) begin
            $display("%0t: status mismatch: expected %s (0x%0h), got 0x%0h",
                     $time, want.name(), want_data, m_axis_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (classify_item(s_axis_tuser[0], s_axis_tdata[ANGLE_BITS-1:0], s_axis_tuser[1],
                          next_status))
          expected_status_q = {expected_status_q, next_status};
      end
    end
    pending <= expected_status_q.size();
  end

endmodule

### tb/sv/tb_top.sv
module tb_top;
  import mddc_pkg::*;

  // Generous ceiling: covers the 64K-tick saturation run plus every item
  // paying the longest sender gap and receiver stall.
  localparam longint RUN_LIMIT = 10_000_000;

  logic                     clk;
  logic                     rst = 1'b1;

  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  // tdata: angle (signed)
  logic [15:0]              s_axis_tdata = '0;
  // tuser: [0] mode (1 = tick), [1] channel (1 = yaw)
  logic [1:0]               s_axis_tuser = '0;

  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  // tdata: status [2:0], zero padding above
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;

  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  cfg_index_t               cfg_index = CFG_STILL_BAND;
  logic [15:0]              cfg_data = '0;

  int                       fail_count;
  int                       pending;

  int                       items_sent;
  bit                       no_gaps;
  bit                       last_chan_sent;
  // Current band settings, used to aim offsets at each class of distance
  int                       still_band_now = 70;
  int                       move_band_now = 286;
  int                       still_ticks_now = 5;

  motion_direction_debounce_classifier i_dut (.*);

  mddc_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #RUN_LIMIT;
    $display("** motion_direction_debounce_classifier: FAILED **");
    $finish;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: ready stretches of random length, broken by random stalls.
  initial begin : result_sink
    int ready_len;
    int stall_len;
    forever begin
      ready_len = $urandom_range(1, 40);
      stall_len = pick_gap();
      m_axis_tready <= 1'b1;
      repeat (ready_len) @(posedge clk);
      if (stall_len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Present one item after an optional gap and hold it until it is taken.
  task automatic send_item(input bit is_tick, input logic [15:0] angle, input bit chan);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= angle;
    s_axis_tuser  <= {chan, is_tick};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    if (!is_tick) last_chan_sent = chan;
  endtask

  task automatic sample(input logic signed [15:0] angle, input bit chan);
    send_item(1'b0, angle, chan);
  endtask

  // Ticks carry junk in the angle and channel bits; the block must ignore them.
  task automatic tick(input int count);
    repeat (count) send_item(1'b1, 16'($urandom), 1'($urandom));
  endtask

  // Drop valid, let every expected result arrive, then let the pipeline empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Valid stays high across back-to-back writes; the caller lowers it.
  task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_config(input logic [14:0] sband, input logic [14:0] mband,
                             input logic [15:0] ticks, input logic [15:0] pitch_goal,
                             input logic [15:0] yaw_goal);
    write_reg(CFG_STILL_BAND, {1'b0, sband});
    write_reg(CFG_MOVE_BAND, {1'b0, mband});
    write_reg(CFG_STILL_TICKS, ticks);
    write_reg(CFG_PITCH_TARGET, pitch_goal);
    write_reg(CFG_YAW_TARGET, yaw_goal);
    cfg_valid       <= 1'b0;
    still_band_now  = sband;
    move_band_now   = mband;
    still_ticks_now = ticks;
  endtask

  // Pick an angle near base: inside the still band, between bands, beyond the
  // move band, or right on one of the band edges.
  function automatic logic [15:0] near_angle(input logic signed [15:0] base);
    int off;
    int sum;
    case ($urandom_range(0, 3))
      0: off = $urandom_range(0, still_band_now);
      1: off = (move_band_now > still_band_now) ?
               $urandom_range(still_band_now + 1, move_band_now) : move_band_now;
      2: off = $urandom_range(move_band_now + 1, move_band_now + 401);
      default: begin
        case ($urandom_range(0, 3))
          0: off = still_band_now;
          1: off = still_band_now + 1;
          2: off = move_band_now;
          default: off = move_band_now + 1;
        endcase
      end
    endcase
    if ($urandom_range(0, 1)) off = -off;
    sum = int'(base) + off;
    if (sum > 32767) sum = 32767;
    if (sum < -32768) sum = -32768;
    return 16'(sum);
  endfunction

  // Mostly latch-then-follow sequences, with some raw noise mixed in.
  task automatic run_phase(input int count);
    int               start;
    int               steps;
    int               ticks;
    bit               chan;
    logic signed [15:0] base;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(1'($urandom), 16'($urandom), 1'($urandom));
      end else begin
        // Switching channel forces a fresh reference at base.
        chan = last_chan_sent;
        if ($urandom_range(0, 9) < 7) chan = ~chan;
        base = 16'($urandom);
        sample(base, chan);
        steps = $urandom_range(1, 4);
        repeat (steps) begin
          ticks = (still_ticks_now <= 10) ? $urandom_range(0, still_ticks_now + 2)
                                          : $urandom_range(0, 8);
          tick(ticks);
          sample(near_angle(base), chan);
        end
      end
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: still 70, move 286, ticks 5, both goals 0.
    sample(16'sd0, 1'b0);          // latch, goal not above -> falling wanted
    sample(16'sd70, 1'b0);         // on the still edge, timer not yet past limit
    tick(6);
    sample(-16'sd70, 1'b0);        // timer past limit -> constant
    sample(16'sd100, 1'b0);        // latch
    sample(16'sd387, 1'b0);        // one past move band, rising -> away
    sample(-16'sd100, 1'b0);       // latch, goal above -> rising wanted
    sample(16'sd187, 1'b0);        // towards
    sample(16'sd0, 1'b0);          // latch
    sample(16'sd71, 1'b0);         // just past still band -> toggling
    sample(16'sd286, 1'b0);        // on the move edge -> still toggling
    sample(16'sh8000, 1'b1);       // channel change latches at the minimum
    sample(16'sh7FFF, 1'b1);       // full-scale swing
    sample(16'sh7FFF, 1'b1);       // latch at the maximum
    sample(16'sh8000, 1'b1);       // full-scale swing the other way
    send_item(1'b1, 16'hFFFF, 1'b1);
    sample(16'sd5, 1'b0);          // channel change latches again
    settle();

    // Overlapping bands (still wins), zero tick limit, extreme goals.
    load_config(15'h7FFF, 15'd0, 16'd0, 16'sh7FFF, 16'sh8000);
    sample(16'sd0, 1'b0);
    sample(16'sd500, 1'b0);
    tick(1);
    sample(-16'sd500, 1'b0);
    sample(16'sh8000, 1'b1);
    sample(16'sh7FFF, 1'b1);
    settle();

    // Tick limit at the timer's ceiling: a saturated timer never reports constant.
    load_config(15'd0, 15'h7FFF, 16'hFFFF, 16'sh8000, 16'sh7FFF);
    sample(16'sd1000, 1'b0);
    no_gaps = 1'b1;
    tick(65540);
    no_gaps = 1'b0;
    sample(16'sd1000, 1'b0);
    settle();
    // One below the ceiling: the held saturated timer now wins.
    load_config(15'd0, 15'h7FFF, 16'hFFFE, 16'sh8000, 16'sh7FFF);
    sample(16'sd1000, 1'b0);
    sample(16'sd0, 1'b0);
    sample(16'sh7FFF, 1'b0);       // exactly on the widest move band
    sample(16'sh8000, 1'b0);       // one past it
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      load_config(15'($urandom_range(0, 200)), 15'($urandom_range(0, 500)),
                  16'($urandom_range(0, 6)), 16'($urandom), 16'($urandom));
      no_gaps = (phase == 2);
      run_phase(200);
      no_gaps = 1'b0;
      settle();
    end

    if (fail_count == 0) begin
      $display("** motion_direction_debounce_classifier: PASSED **");
    end else begin
      $display("** motion_direction_debounce_classifier: FAILED **");
    end
    $finish;
  end

endmodule
